// ----- rtl/grr_pkg.sv -----
// Shared types, constants and helper functions of the grid ring rotation block.
// Used by grr_rem and grid_ring_rotate under rtl/; depends on nothing else.
`default_nettype none
package grr_pkg;

  // Grid storage geometry
  localparam int MAX_DIM    = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CELL_COUNT = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field and register widths
  localparam int CRD_W     = 4;            // row / col field
  localparam int VAL_W     = 32;           // value / data field
  localparam int DIM_W     = 5;            // size registers and ring bounds
  localparam int LEN_W     = DIM_W + 2;    // ring length and positions
  localparam int SHIFT_W   = 30;           // rotation register
  localparam int REM_CNT_W = $clog2(SHIFT_W + 1);
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd2;

  // Item kinds carried on in_tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Remainder unit request and response
  typedef struct packed {
    logic               start;
    logic [SHIFT_W-1:0] dividend;
    logic [LEN_W-1:0]   divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] rem;
  } rem_rsp_t;

  // Low DATA_WIDTH bits of an incoming value, zero-extended when wider
  function automatic logic [DATA_WIDTH-1:0] to_cell(input logic [VAL_W-1:0] v);
    logic [63:0] t;
    t = {32'b0, v};
    return t[DATA_WIDTH-1:0];
  endfunction

  // Stored word sign-extended, then cut to the result width
  function automatic logic [VAL_W-1:0] from_cell(input logic [DATA_WIDTH-1:0] w);
    logic signed [63:0] t;
    t = 64'(signed'(w));
    return t[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/grr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none
module grr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/grr_rem.sv -----
// Iterative restoring remainder unit: shift amount modulo ring length,
// one dividend bit per cycle. Depends on grr_pkg.
`default_nettype none
module grr_rem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire grr_pkg::rem_req_t req,
  output grr_pkg::rem_rsp_t      rsp
);
  import grr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SHIFT_W-1:0]   dvd_r, dvd_nxt;
  logic [LEN_W-1:0]     dvs_r, dvs_nxt;
  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [LEN_W:0]       trial;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[SHIFT_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = REM_CNT_W'(SHIFT_W);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[SHIFT_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = LEN_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = LEN_W'(trial);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == REM_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ----- rtl/grid_ring_rotate.sv -----
// Top level of the grid ring rotation block: stream ports, sequencer, cell RAM.
// Depends on grr_pkg, grr_ram and grr_rem.
//
// A write transaction (in_tuser low) is stored in the cell RAM in the cycle it is
// accepted, so writes stream at one per cycle while no read is in progress. A read
// transaction (in_tuser high) first locates the ring and the position on it, then
// the bit-serial remainder unit reduces the shift register modulo the ring length
// (one bit per cycle over the 30-bit register), then the rotated position is mapped
// back to a cell and the RAM is read. A read outside the configured size skips all
// of that and returns zero with bad_coordinate set; a cell on no ring is read
// directly. in_tready is low while a read is in progress. The result sits in an
// output register, so a new item is taken while that result waits on out_tready.
// Reading a cell that was never written returns an undefined word.
`default_nettype none
module grid_ring_rotate (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input stream
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [39:0]                  in_tdata,  // row[3:0], col[7:4], value[39:8]
  input  wire logic                         in_tuser,  // action
  // Result stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [39:0]                       out_tdata, // data[31:0], bad_coordinate[32]
  // Configuration write port
  input  wire logic                         cfg_we,
  input  wire logic [grr_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [grr_pkg::SHIFT_W-1:0]  cfg_wdata
);
  import grr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LAYER = 3'd1;
  localparam logic [2:0] S_POS   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_QADJ  = 3'd4;
  localparam logic [2:0] S_MAP   = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // Configuration registers
  logic [DIM_W-1:0]   rows_r, cols_r;
  logic [SHIFT_W-1:0] shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(16);
      cols_r  <= DIM_W'(16);
      shift_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS:  rows_r  <= cfg_wdata[DIM_W-1:0];
        REG_COLS:  cols_r  <= cfg_wdata[DIM_W-1:0];
        REG_SHIFT: shift_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Grid size in use, saturated at the store dimension
  logic [DIM_W-1:0] m, n;
  assign m = (32'(rows_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : rows_r;
  assign n = (32'(cols_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : cols_r;

  // Input fields
  logic [CRD_W-1:0] in_row, in_col;
  logic [VAL_W-1:0] in_value;
  logic             in_fire;
  assign in_row   = in_tdata[CRD_W-1:0];
  assign in_col   = in_tdata[2*CRD_W-1:CRD_W];
  assign in_value = in_tdata[2*CRD_W+VAL_W-1:2*CRD_W];
  assign in_fire  = in_tvalid && in_tready;

  // Sequencer registers
  logic [2:0]       state_r, state_nxt;
  logic [DIM_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [DIM_W-1:0] layer_r, layer_nxt;
  logic [DIM_W-1:0] bottom_r, bottom_nxt, right_r, right_nxt;
  logic [LEN_W-1:0] w1_r, w1_nxt, h1_r, h1_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, pos_r, pos_nxt, q_r, q_nxt;
  logic [DIM_W-1:0] src_row_r, src_row_nxt, src_col_r, src_col_nxt;
  logic             bad_r, bad_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [VAL_W-1:0] out_data_r, out_data_nxt;
  logic             out_bad_r, out_bad_nxt;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic                  ram_re;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // Combinational helpers for the ring arithmetic
  logic [DIM_W-1:0] far_r, far_c, lay_a, lay_b, lay_min, layers;
  logic [DIM_W-1:0] bot_c, rgt_c;
  logic [LEN_W-1:0] w1_c, h1_c, pos_c;
  logic [LEN_W:0]   qsum;
  logic [LEN_W-1:0] a2, a3;

  always_comb begin
    // Ring index of the requested cell
    far_r   = m - 1'b1 - row_r;
    far_c   = n - 1'b1 - col_r;
    lay_a   = (row_r < col_r) ? row_r : col_r;
    lay_b   = (far_r < far_c) ? far_r : far_c;
    lay_min = (lay_a < lay_b) ? lay_a : lay_b;
    layers  = ((m >> 1) < (n >> 1)) ? (m >> 1) : (n >> 1);

    // Ring bounds and clockwise position
    bot_c = m - 1'b1 - layer_r;
    rgt_c = n - 1'b1 - layer_r;
    w1_c  = LEN_W'(rgt_c - layer_r);
    h1_c  = LEN_W'(bot_c - layer_r);
    if (row_r == layer_r) begin
      pos_c = LEN_W'(col_r - layer_r);
    end else if (col_r == rgt_c) begin
      pos_c = w1_c + LEN_W'(row_r - layer_r);
    end else if (row_r == bot_c) begin
      pos_c = w1_c + h1_c + LEN_W'(rgt_c - col_r);
    end else begin
      pos_c = (w1_c << 1) + h1_c + LEN_W'(bot_c - row_r);
    end

    // Rotated position, one conditional subtract
    qsum = {1'b0, pos_r} + {1'b0, rem_rsp.rem};

    // Segment boundaries
    a2 = w1_r + h1_r;
    a3 = (w1_r << 1) + h1_r;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    layer_nxt      = layer_r;
    bottom_nxt     = bottom_r;
    right_nxt      = right_r;
    w1_nxt         = w1_r;
    h1_nxt         = h1_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    q_nxt          = q_r;
    src_row_nxt    = src_row_r;
    src_col_nxt    = src_col_r;
    bad_nxt        = bad_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_bad_nxt    = out_bad_r;
    rem_req.start    = 1'b0;
    rem_req.dividend = shift_r;
    rem_req.divisor  = len_r;
    ram_re           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire && in_tuser == ACT_READ) begin
          row_nxt   = DIM_W'(in_row);
          col_nxt   = DIM_W'(in_col);
          state_nxt = S_LAYER;
        end
      end
      S_LAYER: begin
        bad_nxt     = (row_r >= m) || (col_r >= n);
        layer_nxt   = lay_min;
        src_row_nxt = row_r;
        src_col_nxt = col_r;
        if ((row_r >= m) || (col_r >= n)) begin
          state_nxt = S_OUT;
        end else if (lay_min < layers) begin
          state_nxt = S_POS;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_POS: begin
        bottom_nxt      = bot_c;
        right_nxt       = rgt_c;
        w1_nxt          = w1_c;
        h1_nxt          = h1_c;
        len_nxt         = (w1_c + h1_c) << 1;
        pos_nxt         = pos_c;
        rem_req.start   = 1'b1;
        rem_req.divisor = (w1_c + h1_c) << 1;
        state_nxt       = S_DIV;
      end
      S_DIV: begin
        if (rem_rsp.done) begin
          state_nxt = S_QADJ;
        end
      end
      S_QADJ: begin
        if (qsum >= {1'b0, len_r}) begin
          q_nxt = LEN_W'(qsum - {1'b0, len_r});
        end else begin
          q_nxt = LEN_W'(qsum);
        end
        state_nxt = S_MAP;
      end
      S_MAP: begin
        if (q_r < w1_r) begin
          src_row_nxt = layer_r;
          src_col_nxt = layer_r + DIM_W'(q_r);
        end else if (q_r < a2) begin
          src_row_nxt = layer_r + DIM_W'(q_r - w1_r);
          src_col_nxt = right_r;
        end else if (q_r < a3) begin
          src_row_nxt = bottom_r;
          src_col_nxt = right_r - DIM_W'(q_r - a2);
        end else begin
          src_row_nxt = bottom_r - DIM_W'(q_r - a3);
          src_col_nxt = layer_r;
        end
        state_nxt = S_RD;
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_bad_nxt    = bad_r;
          out_data_nxt   = bad_r ? '0 : from_cell(ram_rdata);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    layer_r   <= layer_nxt;
    bottom_r  <= bottom_nxt;
    right_r   <= right_nxt;
    w1_r      <= w1_nxt;
    h1_r      <= h1_nxt;
    len_r     <= len_nxt;
    pos_r     <= pos_nxt;
    q_r       <= q_nxt;
    src_row_r <= src_row_nxt;
    src_col_r <= src_col_nxt;
    bad_r     <= bad_nxt;
    out_data_r <= out_data_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  // Remainder unit used by the sequencer
  grr_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // Cell store: written straight from the input, read by the sequencer
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;

  assign ram_we    = in_fire && (in_tuser == ACT_WRITE) &&
                     (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign ram_waddr = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign ram_raddr = ADDR_W'(32'(src_row_r) * MAX_DIM + 32'(src_col_r));

  grr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (to_cell(in_value)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Ports
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_bad_r, out_data_r};

  // Remainder result only arrives while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> state_r == S_DIV)
    else $error("remainder done outside divide state");

  // Reduced shift is below the ring length
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_QADJ |-> rem_rsp.rem < len_r)
    else $error("remainder not below ring length");

  // Rotated position stays on the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAP |-> q_r < len_r)
    else $error("rotated position off the ring");

  // Source cell lies inside the configured grid
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> (src_row_r < m) && (src_col_r < n))
    else $error("source cell outside configured grid");

endmodule
`default_nettype wire

// ----- tb/tb_grid_ring_rotate.sv -----
// Self-checking testbench for grid_ring_rotate: preload, directed and random traffic.
// Depends on grr_pkg and rtl/grid_ring_rotate.sv; a scoreboard class predicts each read.
`default_nettype none
module tb_grid_ring_rotate;
  import grr_pkg::*;

  localparam int RUN_LIMIT   = 1000000;  // cycles before the run is declared hung
  localparam int SETTLE_CYC  = 45;       // longest read latency plus margin
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 30;

  typedef enum int {RDY_OPEN, RDY_COIN, RDY_STRETCH} stall_mode_t;

  // Expected read result: rotated word and coordinate flag
  typedef struct {
    logic [VAL_W-1:0] data;
    logic             bad;
  } read_result_t;

  // Scoreboard: keeps its own grid and registers, predicts every read
  class read_board_t;
    logic [VAL_W-1:0] grid_word [CELL_COUNT];
    int unsigned      rows, cols, shift;
    read_result_t     pending_reads[$];
    int               errors, n_writes, n_reads, n_bad, n_checked;

    function new();
      rows  = 16;
      cols  = 16;
      shift = 0;
      foreach (grid_word[i]) grid_word[i] = '0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SHIFT_W-1:0] val);
      case (idx)
        REG_ROWS:  rows  = val[DIM_W-1:0];
        REG_COLS:  cols  = val[DIM_W-1:0];
        REG_SHIFT: shift = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_reads.size();
    endfunction

    // Word found at (r, c) once every ring is rotated by the shift register
    function void rotated_word(input logic [CRD_W-1:0] r_in, c_in,
                               output logic [VAL_W-1:0] word, output logic bad);
      int unsigned m, n, r, c, ly, layers, top, left, bot, rgt, w, h, len, p, q, sr, sc;
      m = (rows > MAX_DIM) ? MAX_DIM : rows;
      n = (cols > MAX_DIM) ? MAX_DIM : cols;
      r = r_in;
      c = c_in;
      if (r >= m || c >= n) begin
        word = '0;
        bad  = 1'b1;
        return;
      end
      ly = (r < c) ? r : c;
      if (m - 1 - r < ly) ly = m - 1 - r;
      if (n - 1 - c < ly) ly = n - 1 - c;
      layers = ((m / 2) < (n / 2)) ? (m / 2) : (n / 2);
      sr = r;
      sc = c;
      // cells on no ring (center line or block) stay where they are
      if (ly < layers) begin
        top = ly;
        left = ly;
        bot = m - 1 - ly;
        rgt = n - 1 - ly;
        w = rgt - left + 1;
        h = bot - top + 1;
        len = 2 * (w - 1) + 2 * (h - 1);
        // clockwise position from the ring's top-left corner
        if (r == top)      p = c - left;
        else if (c == rgt) p = (w - 1) + (r - top);
        else if (r == bot) p = (w - 1) + (h - 1) + (rgt - c);
        else               p = 2 * (w - 1) + (h - 1) + (bot - r);
        q = (p + shift % len) % len;
        if (q < w - 1) begin
          sr = top;
          sc = left + q;
        end else if (q < (w - 1) + (h - 1)) begin
          sr = top + (q - (w - 1));
          sc = rgt;
        end else if (q < 2 * (w - 1) + (h - 1)) begin
          sr = bot;
          sc = rgt - (q - (w - 1) - (h - 1));
        end else begin
          sr = bot - (q - 2 * (w - 1) - (h - 1));
          sc = left;
        end
      end
      word = grid_word[sr * MAX_DIM + sc];
      bad  = 1'b0;
    endfunction

    // Accepted input transaction: store a write, queue the answer of a read
    function void note_item(input logic act, input logic [CRD_W-1:0] r, c,
                            input logic [VAL_W-1:0] v);
      read_result_t res;
      if (act == ACT_WRITE) begin
        grid_word[r * MAX_DIM + c] = v;
        n_writes++;
      end else begin
        rotated_word(r, c, res.data, res.bad);
        if (res.bad) n_bad++;
        n_reads++;
        pending_reads = {pending_reads, res};
      end
    endfunction

    // Accepted result transaction against the oldest expected read
    function void check_read(input logic [VAL_W-1:0] data, input logic bad);
      read_result_t res;
      if (pending_reads.size() == 0) begin
        $error("result data=%h bad_coordinate=%b with no read outstanding", data, bad);
        errors++;
        return;
      end
      res = pending_reads.pop_front();
      n_checked++;
      if (data !== res.data) begin
        $error("data: expected %h, actual %h", res.data, data);
        errors++;
      end
      if (bad !== res.bad) begin
        $error("bad_coordinate: expected %b, actual %b", res.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [39:0]          in_tdata;   // row[3:0], col[7:4], value[39:8]
  logic                 in_tuser;   // action
  logic                 out_tvalid;
  logic                 out_tready;
  logic [39:0]          out_tdata;  // data[31:0], bad_coordinate[32]
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [SHIFT_W-1:0]   cfg_wdata;

  read_board_t board = new();

  int          cycle_cnt = 0;
  int          burst_left = 0;
  int          rdy_run = 0;
  stall_mode_t rdy_mode = RDY_OPEN;
  int unsigned cur_rows = 16;
  int unsigned cur_cols = 16;
  int          n_phases = 1;

  grid_ring_rotate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads outstanding", cycle_cnt, board.pending());
      $display("tb_grid_ring_rotate: FAIL");
      $finish;
    end
  end

  // Monitors: configuration writes, accepted inputs, accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.set_reg(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready)
        board.note_item(in_tuser, in_tdata[3:0], in_tdata[7:4], in_tdata[39:8]);
      if (out_tvalid && out_tready) board.check_read(out_tdata[31:0], out_tdata[32]);
    end
  end

  // Receiver back-pressure: the mode changes at the end of each random-length run
  always @(posedge clk) begin
    if (rdy_run == 0) begin
      rdy_mode = stall_mode_t'($urandom_range(0, 2));
      rdy_run  = $urandom_range(20, 150);
    end
    rdy_run--;
    case (rdy_mode)
      RDY_OPEN:    out_tready <= 1'b1;
      RDY_COIN:    out_tready <= 1'($urandom_range(0, 1));
      RDY_STRETCH: out_tready <= ((rdy_run % 16) < 10);
      default:     out_tready <= 1'b1;
    endcase
  end

  // One input transaction; the sender runs in bursts with random gaps
  task automatic send_item(input logic act, input logic [CRD_W-1:0] r, c,
                           input logic [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {v, c, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every read has been answered and the block settles
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // New register setting, written while the block is idle
  task automatic set_regs(input logic [DIM_W-1:0] rws, cls, input logic [SHIFT_W-1:0] sh);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ROWS;
    cfg_wdata <= SHIFT_W'(rws);
    @(posedge clk);
    cfg_addr  <= REG_COLS;
    cfg_wdata <= SHIFT_W'(cls);
    @(posedge clk);
    cfg_addr  <= REG_SHIFT;
    cfg_wdata <= sh;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_rows = rws;
    cur_cols = cls;
    n_phases++;
  endtask

  // Coordinate mostly inside the configured size, sometimes anywhere
  function automatic logic [CRD_W-1:0] pick_coord(input int unsigned dim);
    int unsigned lim;
    lim = (dim > MAX_DIM) ? MAX_DIM : dim;
    if (lim == 0 || $urandom_range(0, 7) == 0)
      return CRD_W'($urandom_range(0, MAX_DIM - 1));
    return CRD_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 3))
      0:       return SHIFT_W'($urandom_range(0, 64));
      1:       return 30'd1000000000;
      default: return SHIFT_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [DIM_W-1:0] rws, cls;
    logic             act;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= ACT_WRITE;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_ROWS;
    cfg_wdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every cell so that no read ever lands on an unwritten word
    for (int i = 0; i < CELL_COUNT; i++)
      send_item(ACT_WRITE, i[7:4], i[3:0], $urandom);

    // Directed: reset sizes, no rotation, extreme values in the corners
    send_item(ACT_WRITE, 4'd0, 4'd0, 32'h8000_0000);
    send_item(ACT_WRITE, 4'd15, 4'd15, 32'h7FFF_FFFF);
    send_item(ACT_READ, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_item(ACT_READ, 4'd15, 4'd15, 32'h0);
    send_item(ACT_READ, 4'd0, 4'd15, 32'h0);
    send_item(ACT_READ, 4'd15, 4'd0, 32'h0);
    send_item(ACT_READ, 4'd8, 4'd8, 32'h0);

    // Odd smaller dimension: center cells stay, outside reads are flagged
    set_regs(5'd5, 5'd7, 30'd3);
    send_item(ACT_READ, 4'd0, 4'd0, 32'h0);
    send_item(ACT_READ, 4'd4, 4'd6, 32'h0);
    send_item(ACT_READ, 4'd2, 4'd3, 32'h0);
    send_item(ACT_READ, 4'd2, 4'd2, 32'h0);
    send_item(ACT_READ, 4'd5, 4'd0, 32'h0);
    send_item(ACT_READ, 4'd0, 4'd7, 32'h0);
    send_item(ACT_READ, 4'd15, 4'd15, 32'h0);
    // a write outside the size is still stored
    send_item(ACT_WRITE, 4'd10, 4'd10, 32'h1234_5678);

    // Zero size: everything is out of range
    set_regs(5'd0, 5'd0, 30'd5);
    send_item(ACT_READ, 4'd0, 4'd0, 32'h0);
    // Size one: no ring at all
    set_regs(5'd1, 5'd1, 30'd7);
    send_item(ACT_READ, 4'd0, 4'd0, 32'h0);
    send_item(ACT_READ, 4'd1, 4'd0, 32'h0);
    // Oversized registers saturate, largest shift value
    set_regs(5'd31, 5'd20, 30'h3FFF_FFFF);
    send_item(ACT_READ, 4'd0, 4'd0, 32'h0);
    send_item(ACT_READ, 4'd10, 4'd10, 32'h0);
    send_item(ACT_READ, 4'd15, 4'd15, 32'h0);

    // Random phases, the first few pinned to the size and shift extremes
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_regs(5'd2, 5'd2, SHIFT_W'($urandom));
        1: set_regs(5'd16, 5'd2, 30'd1000000000);
        2: set_regs(5'd2, 5'd16, 30'h3FFF_FFFF);
        3: set_regs(5'd16, 5'd16, 30'd1000000000);
        default: begin
          rws = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 31)) :
                                              DIM_W'($urandom_range(2, 16));
          cls = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 31)) :
                                              DIM_W'($urandom_range(2, 16));
          set_regs(rws, cls, pick_shift());
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        act = ($urandom_range(0, 9) < 6) ? ACT_READ : ACT_WRITE;
        send_item(act, pick_coord(cur_rows), pick_coord(cur_cols), $urandom);
      end
    end

    drain();
    $display("covered %0d writes and %0d reads (%0d out of range) over %0d register settings",
             board.n_writes, board.n_reads, board.n_bad, n_phases);
    $display("%0d results checked in %0d cycles", board.n_checked, cycle_cnt);
    if (board.pending() != 0) begin
      $error("%0d reads left without a result", board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("tb_grid_ring_rotate: PASS");
    end else begin
      $display("tb_grid_ring_rotate: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
